// ----- design/ppc_pkg.sv -----
package ppc_pkg;

    // Default sizes
    localparam int COUNTER_WIDTH_DEF = 64;
    localparam int CLASS_COUNT_DEF   = 9;

    // Fixed field widths
    localparam int SEL_WIDTH     = 5;
    localparam int FLAG_COUNT    = 9;
    localparam int EVENT_TOTAL   = 13;
    localparam int EV_IDX_WIDTH  = 4;
    localparam int SAMPLE_WIDTH  = 29;
    localparam int S_DATA_WIDTH  = 32;
    localparam int M_DATA_WIDTH  = 72;
    localparam int VALUE_WIDTH   = 64;

    // Event counter slots
    localparam int EV_FETCH_ENTER = 0;
    localparam int EV_FETCH_FLUSH = 1;
    localparam int EV_FETCH_MISS  = 2;
    localparam int EV_BUS_REQS    = 3;
    localparam int EV_BUS_TOTAL   = 4;
    localparam int EV_LOAD_REQS   = 5;
    localparam int EV_LOAD_TOTAL  = 6;
    localparam int EV_STORE_REQS  = 7;
    localparam int EV_STORE_TOTAL = 8;
    localparam int EV_FETCH_STALL = 9;
    localparam int EV_MEM_STALL   = 10;
    localparam int EV_RAW_STALL   = 11;
    localparam int EV_COMMITS     = 12;

    // Read selector codes
    localparam logic [SEL_WIDTH-1:0] SEL_CYCLES      = 5'd0;
    localparam logic [SEL_WIDTH-1:0] SEL_EVENT_LAST  = 5'd13;
    localparam logic [SEL_WIDTH-1:0] SEL_CLASS_FIRST = 5'd14;

    // One pipeline sample, last field in the lowest bits
    typedef struct packed {
        logic [SEL_WIDTH-1:0]  read_select;
        logic [FLAG_COUNT-1:0] class_flags;
        logic                  commit_valid;
        logic [2:0]            stall_events;
        logic                  store_finish;
        logic                  store_begin;
        logic                  load_finish;
        logic                  load_begin;
        logic                  fetch_bus_response;
        logic                  fetch_bus_request;
        logic [3:0]            fetch_events;
        logic                  start_req;
    } sample_t;

    // Result of one sample
    typedef struct packed {
        logic                   counting_on;
        logic [VALUE_WIDTH-1:0] read_value;
    } result_t;

endpackage

// ----- design/ppc_latency_tracker.sv -----
module ppc_latency_tracker #(
    parameter int COUNTER_WIDTH = ppc_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     level,
    input  logic                     fin,
    input  logic [COUNTER_WIDTH-1:0] cycle_upd,
    output logic                     done,
    output logic [COUNTER_WIDTH-1:0] elapsed
);

    logic                     prev_reg;
    logic                     open_reg;
    logic [COUNTER_WIDTH-1:0] start_reg;
    logic                     rise;
    logic                     open_mid;

    // Open on a rising begin edge, close on finish
    assign rise     = level & ~prev_reg;
    assign open_mid = open_reg | rise;
    assign done     = open_mid & fin;
    assign elapsed  = rise ? '0 : (cycle_upd - start_reg);

    // Advance tracker state on counted samples only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            open_reg  <= 1'b0;
            start_reg <= '0;
        end
        else if (en)
        begin
            prev_reg <= level;
            open_reg <= open_mid & ~fin;
            if (rise)
            begin
                start_reg <= cycle_upd;
            end
        end
    end

endmodule

// ----- design/ppc_core.sv -----
module ppc_core #(
    parameter int COUNTER_WIDTH = ppc_pkg::COUNTER_WIDTH_DEF,
    parameter int CLASS_COUNT   = ppc_pkg::CLASS_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  ppc_pkg::sample_t  sample,
    output ppc_pkg::result_t  result
);

    localparam int CLS_IDX_WIDTH = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

    logic                     armed_reg;
    logic                     armed_next;
    logic                     cnt_en;
    logic [COUNTER_WIDTH-1:0] cycle_reg;
    logic [COUNTER_WIDTH-1:0] cycle_next;
    logic [COUNTER_WIDTH-1:0] ev_reg [ppc_pkg::EVENT_TOTAL];
    logic [COUNTER_WIDTH-1:0] ev_add [ppc_pkg::EVENT_TOTAL];
    logic [COUNTER_WIDTH-1:0] ev_next [ppc_pkg::EVENT_TOTAL];
    logic [COUNTER_WIDTH-1:0] cls_reg [CLASS_COUNT];
    logic [COUNTER_WIDTH-1:0] cls_next [CLASS_COUNT];
    logic [ppc_pkg::FLAG_COUNT-1:0] cls_hit;
    logic [2:0]               trk_level;
    logic [2:0]               trk_fin;
    logic [2:0]               trk_done;
    logic [COUNTER_WIDTH-1:0] trk_elapsed [3];
    logic [ppc_pkg::SEL_WIDTH-1:0] ev_sel;
    logic [ppc_pkg::SEL_WIDTH-1:0] cls_sel;
    logic [COUNTER_WIDTH-1:0] sel_value;

    // Arm on start and stay armed
    assign armed_next = armed_reg | sample.start_req;
    assign cnt_en     = advance & armed_next;
    assign cycle_next = armed_next ? (cycle_reg + 1'b1) : cycle_reg;

    // Latency trackers: fetch bus, load, store
    assign trk_level = {sample.store_begin, sample.load_begin, sample.fetch_bus_request};
    assign trk_fin   = {sample.store_finish, sample.load_finish, sample.fetch_bus_response};

    for (genvar t = 0; t < 3; t++)
    begin : g_trk
        ppc_latency_tracker #(
            .COUNTER_WIDTH (COUNTER_WIDTH)
        ) u_trk (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (cnt_en),
            .level     (trk_level[t]),
            .fin       (trk_fin[t]),
            .cycle_upd (cycle_next),
            .done      (trk_done[t]),
            .elapsed   (trk_elapsed[t])
        );
    end

    // Build the increment of each event counter
    always_comb
    begin
        for (int i = 0; i < ppc_pkg::EVENT_TOTAL; i++)
        begin
            ev_add[i] = '0;
        end
        if (armed_next)
        begin
            ev_add[ppc_pkg::EV_FETCH_ENTER] = COUNTER_WIDTH'(sample.fetch_events[0]);
            ev_add[ppc_pkg::EV_FETCH_FLUSH] = COUNTER_WIDTH'(sample.fetch_events[1]);
            ev_add[ppc_pkg::EV_FETCH_MISS]  = COUNTER_WIDTH'(sample.fetch_events[2]);
            ev_add[ppc_pkg::EV_BUS_REQS]    = COUNTER_WIDTH'(trk_done[0]);
            ev_add[ppc_pkg::EV_BUS_TOTAL]   = trk_done[0] ? trk_elapsed[0] : '0;
            ev_add[ppc_pkg::EV_LOAD_REQS]   = COUNTER_WIDTH'(trk_done[1]);
            ev_add[ppc_pkg::EV_LOAD_TOTAL]  = trk_done[1] ? trk_elapsed[1] : '0;
            ev_add[ppc_pkg::EV_STORE_REQS]  = COUNTER_WIDTH'(trk_done[2]);
            ev_add[ppc_pkg::EV_STORE_TOTAL] = trk_done[2] ? trk_elapsed[2] : '0;
            ev_add[ppc_pkg::EV_FETCH_STALL] = COUNTER_WIDTH'(sample.fetch_events[3]);
            ev_add[ppc_pkg::EV_MEM_STALL]   = COUNTER_WIDTH'(sample.stall_events[0]);
            ev_add[ppc_pkg::EV_RAW_STALL]   = COUNTER_WIDTH'(sample.stall_events[1]);
            ev_add[ppc_pkg::EV_COMMITS]     = COUNTER_WIDTH'(sample.commit_valid);
        end
    end

    always_comb
    begin
        for (int i = 0; i < ppc_pkg::EVENT_TOTAL; i++)
        begin
            ev_next[i] = ev_reg[i] + ev_add[i];
        end
    end

    // Isolate the lowest set class flag
    assign cls_hit = sample.class_flags & (~sample.class_flags + 1'b1);

    always_comb
    begin
        for (int i = 0; i < CLASS_COUNT; i++)
        begin
            cls_next[i] = cls_reg[i];
            if (i < ppc_pkg::FLAG_COUNT)
            begin
                if (armed_next && sample.commit_valid && cls_hit[i])
                begin
                    cls_next[i] = cls_reg[i] + 1'b1;
                end
            end
        end
    end

    // Commit updated state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            cycle_reg <= '0;
            for (int i = 0; i < ppc_pkg::EVENT_TOTAL; i++)
            begin
                ev_reg[i] <= '0;
            end
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                cls_reg[i] <= '0;
            end
        end
        else if (cnt_en)
        begin
            armed_reg <= 1'b1;
            cycle_reg <= cycle_next;
            for (int i = 0; i < ppc_pkg::EVENT_TOTAL; i++)
            begin
                ev_reg[i] <= ev_next[i];
            end
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                cls_reg[i] <= cls_next[i];
            end
        end
    end

    // Select the counter to read back, after this sample's update
    assign ev_sel  = sample.read_select - 1'b1;
    assign cls_sel = sample.read_select - ppc_pkg::SEL_CLASS_FIRST;

    always_comb
    begin
        sel_value = '0;
        if (sample.read_select == ppc_pkg::SEL_CYCLES)
        begin
            sel_value = cycle_next;
        end
        else if (sample.read_select <= ppc_pkg::SEL_EVENT_LAST)
        begin
            sel_value = ev_next[ev_sel[ppc_pkg::EV_IDX_WIDTH-1:0]];
        end
        else if (32'(cls_sel) < CLASS_COUNT)
        begin
            sel_value = cls_next[cls_sel[CLS_IDX_WIDTH-1:0]];
        end
    end

    assign result.read_value  = ppc_pkg::VALUE_WIDTH'(sel_value);
    assign result.counting_on = armed_next;

endmodule

// ----- design/pipeline_performance_counters.sv -----
// Path: an accepted item is held in the input register, and its result is captured
// in the result register, which drives m_tdata.
// Throughput: one item per cycle while m_tready does not back-pressure; the counter
// update and read-back mux sit between the input register and the result register.
// Reset: rst_n asynchronous, active low; clears all counters, the armed flag
// and the latency trackers, and empties both register stages.
module pipeline_performance_counters #(
    parameter int COUNTER_WIDTH = ppc_pkg::COUNTER_WIDTH_DEF,
    parameter int CLASS_COUNT   = ppc_pkg::CLASS_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // start_req, fetch_events[3:0], fetch_bus_request, fetch_bus_response,
    // load_begin, load_finish, store_begin, store_finish, stall_events[2:0],
    // commit_valid, class_flags[8:0], read_select[4:0], zero fill
    input  logic [ppc_pkg::S_DATA_WIDTH-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_value[63:0], counting_on, zero fill
    output logic [ppc_pkg::M_DATA_WIDTH-1:0] m_tdata
);

    logic              in_valid_reg;
    ppc_pkg::sample_t  in_data_reg;
    logic              out_valid_reg;
    ppc_pkg::result_t  out_data_reg;
    ppc_pkg::result_t  core_result;
    logic              advance;

    // Move an item forward when the result register is free or draining
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= ppc_pkg::sample_t'(s_tdata[ppc_pkg::SAMPLE_WIDTH-1:0]);
        end
    end

    // Counter state and read-back
    ppc_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .CLASS_COUNT   (CLASS_COUNT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (in_data_reg),
        .result  (core_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ppc_pkg::M_DATA_WIDTH'(out_data_reg);

endmodule
